/* hdl/segment_cutline_intersect_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the segment and cutting line intersection block
// Shared helpers so that every concurrent check reports the same way.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_CUTLINE_INTERSECT_ASSERT_SVH
`define SEGMENT_CUTLINE_INTERSECT_ASSERT_SVH

// Check that is switched off while reset is held.
`define SCI_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("segment_cutline_intersect assertion failed");

// Check that also covers the reset cycles.
`define SCI_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("segment_cutline_intersect assertion failed");

`endif

/* hdl/sci_pkg.sv */
// ---------------------------------------------------------------------------
// sci_pkg
// Widths and pipeline record types shared by the intersection block.
// ---------------------------------------------------------------------------
package sci_pkg;

  localparam int CW  = 16;          // coordinate width
  localparam int TW  = 16;          // tolerance register width
  localparam int DW  = CW + 1;      // coordinate difference
  localparam int PW  = 2 * DW;      // product of two differences
  localparam int XW  = PW + 1;      // cross product
  localparam int LOW = 18;          // split point of the wide multiplies
  localparam int HW  = XW - LOW;    // upper part of a cross product
  localparam int NW  = DW + XW + 2; // point numerator
  localparam int AW  = NW + 1;      // rounded dividend
  localparam int BW  = XW + 1;      // doubled divisor
  localparam int QB  = CW + 1;      // quotient bits before saturation

  typedef struct packed {
    logic signed [XW-1:0] den;
    logic signed [XW-1:0] nu;
    logic signed [XW-1:0] nt;
    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] sy;
    logic signed [CW-1:0] p1x;
    logic signed [CW-1:0] p1y;
  } sci_cross_t;

  typedef struct packed {
    logic          hit;
    logic          negx;
    logic          negy;
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
    logic [BW-1:0] b;
  } sci_quot_t;

  typedef struct packed {
    logic          hit;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic [AW-1:0] rx;
    logic [AW-1:0] ry;
    logic [BW-1:0] b;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
  } sci_dstage_t;

endpackage

/* hdl/sci_front.sv */
// ---------------------------------------------------------------------------
// sci_front
// Three stages: direction vectors, pairwise products, cross products.
// ---------------------------------------------------------------------------
module sci_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              take,
  input  logic signed [sci_pkg::CW-1:0]     seg_start_x,
  input  logic signed [sci_pkg::CW-1:0]     seg_start_y,
  input  logic signed [sci_pkg::CW-1:0]     seg_end_x,
  input  logic signed [sci_pkg::CW-1:0]     seg_end_y,
  input  logic signed [sci_pkg::CW-1:0]     cut_start_x,
  input  logic signed [sci_pkg::CW-1:0]     cut_start_y,
  input  logic signed [sci_pkg::CW-1:0]     cut_end_x,
  input  logic signed [sci_pkg::CW-1:0]     cut_end_y,
  output logic                              vld,
  output sci_pkg::sci_cross_t               crs
);
  import sci_pkg::*;

  logic [2:0] v;

  logic signed [DW-1:0] sx1, sy1, cx1, cy1, wx1, wy1;
  logic signed [CW-1:0] p1x1, p1y1;

  logic signed [PW-1:0] m_cs, m_sc, m_ws, m_sw, m_wc, m_cw;
  logic signed [DW-1:0] sx2, sy2;
  logic signed [CW-1:0] p1x2, p1y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1  <= DW'(seg_end_x) - DW'(seg_start_x);
      sy1  <= DW'(seg_end_y) - DW'(seg_start_y);
      cx1  <= DW'(cut_end_x) - DW'(cut_start_x);
      cy1  <= DW'(cut_end_y) - DW'(cut_start_y);
      wx1  <= DW'(seg_start_x) - DW'(cut_start_x);
      wy1  <= DW'(seg_start_y) - DW'(cut_start_y);
      p1x1 <= seg_start_x;
      p1y1 <= seg_start_y;

      m_cs <= cx1 * sy1;
      m_sc <= sx1 * cy1;
      m_ws <= wx1 * sy1;
      m_sw <= sx1 * wy1;
      m_wc <= wx1 * cy1;
      m_cw <= cx1 * wy1;
      sx2  <= sx1;
      sy2  <= sy1;
      p1x2 <= p1x1;
      p1y2 <= p1y1;

      crs.den <= XW'(m_cs) - XW'(m_sc);
      crs.nu  <= XW'(m_ws) - XW'(m_sw);
      crs.nt  <= XW'(m_wc) - XW'(m_cw);
      crs.sx  <= sx2;
      crs.sy  <= sy2;
      crs.p1x <= p1x2;
      crs.p1y <= p1y2;
    end
  end

  assign vld = v[2];

endmodule

/* hdl/sci_numer.sv */
// ---------------------------------------------------------------------------
// sci_numer
// Extent test and the point numerators, ready for rounded division.
// ---------------------------------------------------------------------------
module sci_numer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld_in,
  input  sci_pkg::sci_cross_t       crs,
  input  logic [sci_pkg::TW-1:0]    tol,
  output logic                      vld,
  output sci_pkg::sci_quot_t        quo
);
  import sci_pkg::*;

  function automatic logic in_unit(input logic signed [XW-1:0] n,
                                   input logic signed [XW-1:0] d);
    if (d > 0) begin
      return (n >= 0) && (n <= d);
    end
    return (n <= 0) && (n >= d);
  endfunction

  logic [2:0] v;

  logic signed [XW-1:0]  den_i, nu_i, nt_i;
  logic [XW-1:0]         mag_d;
  logic signed [LOW:0]   d_lo, t_lo;
  logic signed [HW-1:0]  d_hi, t_hi;
  logic                  hit_c;

  logic                      hit4, hit5;
  logic signed [XW-1:0]      den4, den5;
  logic signed [CW+LOW:0]    pxl, pyl;
  logic signed [CW+HW-1:0]   pxh, pyh;
  logic signed [DW+LOW:0]    sxl, syl;
  logic signed [DW+HW-1:0]   sxh, syh;
  logic signed [NW-1:0]      nx5, ny5;

  logic [XW-1:0] mag_d5;
  logic [NW-1:0] mag_nx, mag_ny;

  assign den_i = crs.den;
  assign nu_i  = crs.nu;
  assign nt_i  = crs.nt;
  assign mag_d = den_i[XW-1] ? XW'(-den_i) : XW'(den_i);
  assign d_lo  = $signed({1'b0, den_i[LOW-1:0]});
  assign d_hi  = den_i[XW-1:LOW];
  assign t_lo  = $signed({1'b0, nt_i[LOW-1:0]});
  assign t_hi  = nt_i[XW-1:LOW];
  assign hit_c = (mag_d > XW'(tol)) && in_unit(nu_i, den_i) && in_unit(nt_i, den_i);

  assign mag_d5 = den5[XW-1] ? XW'(-den5) : XW'(den5);
  assign mag_nx = nx5[NW-1] ? NW'(-nx5) : NW'(nx5);
  assign mag_ny = ny5[NW-1] ? NW'(-ny5) : NW'(ny5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], vld_in};
    end
  end

  // The numerator is det * x with det = -den, rebuilt from the start point
  // and the fraction numerator along the tested segment.
  always_ff @(posedge clk) begin
    if (en) begin
      hit4 <= hit_c;
      den4 <= den_i;
      pxl  <= crs.p1x * d_lo;
      pxh  <= crs.p1x * d_hi;
      pyl  <= crs.p1y * d_lo;
      pyh  <= crs.p1y * d_hi;
      sxl  <= crs.sx * t_lo;
      sxh  <= crs.sx * t_hi;
      syl  <= crs.sy * t_lo;
      syh  <= crs.sy * t_hi;

      hit5 <= hit4;
      den5 <= den4;
      nx5  <= -(NW'(pxh) <<< LOW) - NW'(pxl) - (NW'(sxh) <<< LOW) - NW'(sxl);
      ny5  <= -(NW'(pyh) <<< LOW) - NW'(pyl) - (NW'(syh) <<< LOW) - NW'(syl);

      quo.hit  <= hit5;
      quo.negx <= nx5[NW-1] ^ ~den5[XW-1];
      quo.negy <= ny5[NW-1] ^ ~den5[XW-1];
      quo.ax   <= AW'({mag_nx, 1'b0}) + AW'(mag_d5);
      quo.ay   <= AW'({mag_ny, 1'b0}) + AW'(mag_d5);
      quo.b    <= {mag_d5, 1'b0};
    end
  end

  assign vld = v[2];

endmodule

/* hdl/sci_div.sv */
// ---------------------------------------------------------------------------
// sci_div
// Pipelined restoring divider, one quotient bit per stage, two lanes
// sharing the divisor.
// ---------------------------------------------------------------------------
module sci_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_in,
  input  sci_pkg::sci_quot_t    quo,
  output logic                  vld,
  output sci_pkg::sci_dstage_t  res
);
  import sci_pkg::*;

  function automatic sci_dstage_t div_step(input sci_dstage_t s, input int unsigned sh);
    logic [AW-1:0] t;
    logic          gx;
    logic          gy;
    sci_dstage_t   r;
    t  = AW'(s.b) << sh;
    gx = s.rx >= t;
    gy = s.ry >= t;
    r  = s;
    if (gx) begin
      r.rx = s.rx - t;
    end
    if (gy) begin
      r.ry = s.ry - t;
    end
    r.qx = s.qx | (QB'(gx) << sh);
    r.qy = s.qy | (QB'(gy) << sh);
    return r;
  endfunction

  logic [QB-1:0] vs;
  sci_dstage_t   first;
  sci_dstage_t   cur [0:QB-1];
  sci_dstage_t   nxt [0:QB-1];
  sci_dstage_t   st  [0:QB-1];

  // A quotient that needs more than QB bits saturates.
  always_comb begin
    first.hit  = quo.hit;
    first.negx = quo.negx;
    first.negy = quo.negy;
    first.ovfx = quo.ax >= (AW'(quo.b) << QB);
    first.ovfy = quo.ay >= (AW'(quo.b) << QB);
    first.rx   = quo.ax;
    first.ry   = quo.ay;
    first.b    = quo.b;
    first.qx   = '0;
    first.qy   = '0;
  end

  always_comb begin
    cur[0] = first;
    for (int i = 1; i < QB; i++) begin
      cur[i] = st[i-1];
    end
    for (int i = 0; i < QB; i++) begin
      nxt[i] = div_step(cur[i], QB - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[QB-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QB; i++) begin
        st[i] <= nxt[i];
      end
    end
  end

  assign vld = vs[QB-1];
  assign res = st[QB-1];

endmodule

/* hdl/segment_cutline_intersect.sv */
// ---------------------------------------------------------------------------
// segment_cutline_intersect
// Intersection of a segment with a cutting segment, Q1.14 coordinates.
// ---------------------------------------------------------------------------
// Takes one segment pair per clock while in_ready is high and returns one
// result per pair, in order. A pair passes 25 register stages: three stages
// of differences and cross products, three stages of extent test and
// numerators, 17 divider stages (one quotient bit each, the longest part),
// one rounding and saturation stage and the output register. A two-entry
// output buffer keeps input accepted while a result waits; in_ready drops
// only when both entries are full. parallel_tolerance is written with
// cfg_write and should change only while no pair is in flight.
module segment_cutline_intersect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sci_pkg::TW-1:0]         parallel_tolerance,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [sci_pkg::CW-1:0]  seg_start_x,
  input  logic signed [sci_pkg::CW-1:0]  seg_start_y,
  input  logic signed [sci_pkg::CW-1:0]  seg_end_x,
  input  logic signed [sci_pkg::CW-1:0]  seg_end_y,
  input  logic signed [sci_pkg::CW-1:0]  cut_start_x,
  input  logic signed [sci_pkg::CW-1:0]  cut_start_y,
  input  logic signed [sci_pkg::CW-1:0]  cut_end_x,
  input  logic signed [sci_pkg::CW-1:0]  cut_end_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic signed [sci_pkg::CW-1:0]  cross_x,
  output logic signed [sci_pkg::CW-1:0]  cross_y
);
  import sci_pkg::*;

  function automatic logic [CW-1:0] round_sat(input logic [QB-1:0] q,
                                              input logic ovf,
                                              input logic neg);
    logic [QB-1:0] nq;
    nq = -q;
    if (neg) begin
      if (ovf || (q > QB'(2 ** (CW - 1)))) begin
        return {1'b1, {(CW-1){1'b0}}};
      end
      return nq[CW-1:0];
    end
    if (ovf || (q > QB'(2 ** (CW - 1) - 1))) begin
      return {1'b0, {(CW-1){1'b1}}};
    end
    return q[CW-1:0];
  endfunction

  logic [TW-1:0] tol;
  logic          en;
  logic          take;

  logic          f_vld, n_vld, d_vld;
  sci_cross_t    crs;
  sci_quot_t     quo;
  sci_dstage_t   res;

  logic          pv;
  logic          p_hit;
  logic [CW-1:0] p_x, p_y;

  logic          sv;
  logic          s_hit;
  logic [CW-1:0] s_x, s_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_write) begin
      tol <= parallel_tolerance;
    end
  end

  assign en       = !sv;
  assign in_ready = !sv;
  assign take     = in_valid && in_ready;

  sci_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .take        (take),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y),
    .cut_start_x (cut_start_x),
    .cut_start_y (cut_start_y),
    .cut_end_x   (cut_end_x),
    .cut_end_y   (cut_end_y),
    .vld         (f_vld),
    .crs         (crs)
  );

  sci_numer u_numer (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (f_vld),
    .crs    (crs),
    .tol    (tol),
    .vld    (n_vld),
    .quo    (quo)
  );

  sci_div u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (n_vld),
    .quo    (quo),
    .vld    (d_vld),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hit <= res.hit;
      p_x   <= res.hit ? round_sat(res.qx, res.ovfx, res.negx) : '0;
      p_y   <= res.hit ? round_sat(res.qy, res.ovfy, res.negy) : '0;
    end
  end

  // The pipeline moves whenever the skid entry is empty; a transaction that
  // leaves it while the output is stalled parks in the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sv        <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= sv || (en && pv);
      sv        <= 1'b0;
    end else if (en && pv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (sv) begin
        hit     <= s_hit;
        cross_x <= s_x;
        cross_y <= s_y;
      end else begin
        hit     <= p_hit;
        cross_x <= p_x;
        cross_y <= p_y;
      end
    end else if (en && pv) begin
      s_hit <= p_hit;
      s_x   <= p_x;
      s_y   <= p_y;
    end
  end

endmodule

/* hdl/sci_check.sv */
// ---------------------------------------------------------------------------
// sci_check
// Port-level checks for the intersection block, bound to the top level.
// ---------------------------------------------------------------------------
`include "segment_cutline_intersect_assert.svh"

module sci_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic signed [sci_pkg::CW-1:0] cross_x,
  input logic signed [sci_pkg::CW-1:0] cross_y
);
  import sci_pkg::*;

  // A missed pair always reports the origin.
  `SCI_ASSERT(a_miss_zero, clk, rst, out_valid && !hit |-> cross_x == '0 && cross_y == '0)

  `SCI_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(cross_x) && $stable(cross_y))

  // Input back-pressure only appears when a result is waiting at the output.
  `SCI_ASSERT(a_ready_low, clk, rst, !in_ready |-> out_valid && !$past(out_valid && out_ready))

  `SCI_ASSERT_NR(a_reset, clk, rst |=> !out_valid && in_ready)

endmodule

bind segment_cutline_intersect sci_check u_sci_check (.*);
